// File: rtl/core/consensus_leader_election_macros.svh
// Assertion macros shared by the election block's modules.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef CONSENSUS_LEADER_ELECTION_MACROS_SVH
`define CONSENSUS_LEADER_ELECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("election block assertion failed");

// Next-cycle implication, disabled during reset.
`define CLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("election block assertion failed");

`endif

// File: rtl/core/cle_pkg.sv
// Types and constants of the leader election block.
// No dependencies; imported by every module of the block.
package cle_pkg;

    localparam int MAX_NODES_DEF   = 16;
    localparam int TERM_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 15;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_ADDR_W      = 3;

    localparam logic [4:0] VOTE_NONE          = 5'd16;
    localparam logic [4:0] CLUSTER_SIZE_RST   = 5'd3;
    localparam logic [8:0] ELECT_TIMEOUT_RST  = 9'd200;
    localparam logic [7:0] HB_INTERVAL_RST    = 8'd50;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_VOTE       = 2'd1,
        REQ_VOTE_RSP   = 2'd2,
        REQ_APPEND     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MSG_VOTE       = 2'd0,
        MSG_VOTE_RSP   = 2'd1,
        MSG_APPEND     = 2'd2,
        MSG_APPEND_RSP = 2'd3
    } msg_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NODE_NUMBER  = 3'd0,
        CFG_CLUSTER_SIZE = 3'd1,
        CFG_ELECT_TMO    = 3'd2,
        CFG_HB_INTERVAL  = 3'd3,
        CFG_LOG_LENGTH   = 3'd4,
        CFG_LOG_TERM     = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] msg_term;
        logic [3:0]  sender_id;
        logic [31:0] cand_last_index;
        logic [31:0] cand_last_term;
        logic        granted_in;
    } cle_req_t;

    typedef struct packed {
        logic [1:0]  msg_kind;
        logic [3:0]  dest_id;
        logic [31:0] out_term;
        logic        vote_yes;
        logic [31:0] out_log_index;
        logic [31:0] out_log_term;
        logic [1:0]  node_role;
        logic        last;
    } cle_rsp_t;

    typedef struct packed {
        logic [3:0]  node_number;
        logic [4:0]  cluster_size;
        logic [8:0]  election_timeout_ms;
        logic [7:0]  heartbeat_interval_ms;
        logic [31:0] own_log_length;
        logic [31:0] own_log_last_term;
    } cle_cfg_t;

    // One queued unit of output work: a single reply or a broadcast.
    typedef struct packed {
        logic                 bcast;
        msg_kind_t            kind;
        logic [3:0]           dest;
        logic [31:0]          term;
        logic                 yes;
        role_t                role;
        logic [RES_CNT_W-1:0] count;
    } cle_job_t;

endpackage

// File: rtl/core/cle_queue.sv
// Short FIFO of output jobs between the front and back parts.
// Depends on cle_pkg and the block's assertion macros.
`include "consensus_leader_election_macros.svh"

module cle_queue
    import cle_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cle_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output cle_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cle_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `CLE_ASSERT_IMP(a_q_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `CLE_ASSERT_IMP(a_q_no_pop_empty, pop, count_reg != '0)
    `CLE_ASSERT_NXT(a_q_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/core/cle_front.sv
// Front part: accepts requests, updates role/term/vote/timer state, queues output jobs.
// Depends on cle_pkg.
module cle_front
    import cle_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TERM_BITS = TERM_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  cle_req_t in_req,
    input  cle_cfg_t cfg,
    input  logic     q_full,
    output logic     push,
    output cle_job_t push_job
);

    role_t                role_reg,     role_next;
    logic [TERM_BITS-1:0] term_reg,     term_next;
    logic [4:0]           vholder_reg,  vholder_next;
    logic [4:0]           vcount_reg,   vcount_next;
    logic                 active_reg,   active_next;
    logic [8:0]           silence_reg,  silence_next;
    logic [7:0]           hb_reg,       hb_next;

    logic                 in_acc;
    logic                 emit;
    logic [TERM_BITS-1:0] t;
    logic                 term_gt, term_lt, term_eq;
    logic                 log_ok;
    logic                 grant;
    logic [4:0]           vholder_eff;
    logic [4:0]           vcount_inc;
    logic [9:0]           silence_inc;
    logic [8:0]           hb_inc;
    logic [4:0]           limit;
    logic [4:0]           bcast_raw;
    logic [RES_CNT_W-1:0] bcast_n;
    cle_job_t             job;

    assign in_stall = q_full;
    assign in_acc   = in_valid && !q_full;

    // destinations 0..limit-1 minus self, capped at MAX_RESULTS
    always_comb
    begin
        if (32'(cfg.cluster_size) > 32'(MAX_NODES))
        begin
            limit = 5'(MAX_NODES);
        end
        else
        begin
            limit = cfg.cluster_size;
        end
        bcast_raw = limit - 5'({1'b0, cfg.node_number} < limit);
        bcast_n   = (bcast_raw > 5'(MAX_RESULTS)) ? RES_CNT_W'(MAX_RESULTS)
                                                  : RES_CNT_W'(bcast_raw);
    end

    always_comb
    begin
        t           = TERM_BITS'(in_req.msg_term);
        term_gt     = (t > term_reg);
        term_lt     = (t < term_reg);
        term_eq     = (t == term_reg);
        log_ok      = (cfg.own_log_length == '0)
                   || (in_req.cand_last_term > cfg.own_log_last_term)
                   || ((in_req.cand_last_term == cfg.own_log_last_term)
                       && (in_req.cand_last_index >= cfg.own_log_length));
        vholder_eff = term_gt ? VOTE_NONE : vholder_reg;
        grant       = !term_lt && log_ok
                   && ((vholder_eff == VOTE_NONE) || (vholder_eff == {1'b0, in_req.sender_id}));
        vcount_inc  = (&vcount_reg) ? vcount_reg : vcount_reg + 5'd1;
        silence_inc = {1'b0, silence_reg} + 10'd1;
        hb_inc      = {1'b0, hb_reg} + 9'd1;

        role_next    = role_reg;
        term_next    = term_reg;
        vholder_next = vholder_reg;
        vcount_next  = vcount_reg;
        active_next  = active_reg;
        silence_next = silence_reg;
        hb_next      = hb_reg;
        emit         = 1'b0;
        job          = '0;

        if (in_acc)
        begin
            unique case (in_req.req_type)
                REQ_TICK:
                begin
                    if (role_reg == ROLE_LEADER)
                    begin
                        if (hb_inc > {1'b0, cfg.heartbeat_interval_ms})
                        begin
                            hb_next   = '0;
                            emit      = (bcast_n != '0);
                            job.bcast = 1'b1;
                            job.kind  = MSG_APPEND;
                            job.count = bcast_n;
                        end
                        else
                        begin
                            hb_next = hb_inc[7:0];
                        end
                    end
                    else if (silence_inc > {1'b0, cfg.election_timeout_ms})
                    begin
                        // election start
                        role_next    = ROLE_CANDIDATE;
                        term_next    = term_reg + 1'b1;
                        vholder_next = {1'b0, cfg.node_number};
                        vcount_next  = 5'd1;
                        active_next  = 1'b1;
                        silence_next = '0;
                        if (cfg.cluster_size < 5'd2)
                        begin
                            role_next   = ROLE_LEADER;
                            active_next = 1'b0;
                            hb_next     = '0;
                        end
                        emit      = (bcast_n != '0);
                        job.bcast = 1'b1;
                        job.kind  = MSG_VOTE;
                        job.count = bcast_n;
                    end
                    else
                    begin
                        silence_next = silence_inc[8:0];
                    end
                end
                REQ_VOTE:
                begin
                    if (term_gt)
                    begin
                        term_next    = t;
                        role_next    = ROLE_FOLLOWER;
                        vholder_next = VOTE_NONE;
                        active_next  = 1'b0;
                        silence_next = '0;
                    end
                    if (grant)
                    begin
                        vholder_next = {1'b0, in_req.sender_id};
                        silence_next = '0;
                    end
                    emit      = 1'b1;
                    job.kind  = MSG_VOTE_RSP;
                    job.dest  = in_req.sender_id;
                    job.yes   = grant;
                    job.count = RES_CNT_W'(1);
                end
                REQ_VOTE_RSP:
                begin
                    if (active_reg)
                    begin
                        if (term_gt)
                        begin
                            term_next    = t;
                            role_next    = ROLE_FOLLOWER;
                            vholder_next = VOTE_NONE;
                            active_next  = 1'b0;
                            silence_next = '0;
                        end
                        else if (term_eq && in_req.granted_in)
                        begin
                            vcount_next = vcount_inc;
                            if (vcount_inc > {1'b0, cfg.cluster_size[4:1]})
                            begin
                                role_next   = ROLE_LEADER;
                                active_next = 1'b0;
                                hb_next     = '0;
                            end
                        end
                    end
                end
                REQ_APPEND:
                begin
                    if (term_gt)
                    begin
                        term_next    = t;
                        role_next    = ROLE_FOLLOWER;
                        vholder_next = VOTE_NONE;
                        active_next  = 1'b0;
                    end
                    silence_next = '0;
                    emit      = 1'b1;
                    job.kind  = MSG_APPEND_RSP;
                    job.dest  = in_req.sender_id;
                    job.yes   = 1'b1;
                    job.count = RES_CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end

        // results carry term and role as they stand after the request
        job.term = 32'(term_next);
        job.role = role_next;
    end

    assign push     = emit;
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg    <= ROLE_FOLLOWER;
            term_reg    <= '0;
            vholder_reg <= VOTE_NONE;
            vcount_reg  <= '0;
            active_reg  <= 1'b0;
            silence_reg <= '0;
            hb_reg      <= '0;
        end
        else
        begin
            role_reg    <= role_next;
            term_reg    <= term_next;
            vholder_reg <= vholder_next;
            vcount_reg  <= vcount_next;
            active_reg  <= active_next;
            silence_reg <= silence_next;
            hb_reg      <= hb_next;
        end
    end

endmodule

// File: rtl/core/cle_back.sv
// Back part: expands queued jobs into responses, one per cycle while out_stall is low, into an output register.
// Depends on cle_pkg and the block's assertion macros.
`include "consensus_leader_election_macros.svh"

module cle_back
    import cle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cle_cfg_t cfg,
    input  logic     q_valid,
    input  cle_job_t q_job,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output cle_rsp_t out_rsp
);

    back_state_t          state_reg, state_next;
    cle_job_t             job_reg;
    logic [4:0]           idx_reg;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic                 out_valid_reg;
    cle_rsp_t             out_reg;

    logic                 emit;
    logic                 is_last;
    logic [4:0]           dest;
    cle_rsp_t             rsp;

    // broadcast skips this node's own number
    always_comb
    begin
        if (job_reg.bcast)
        begin
            dest = (idx_reg == {1'b0, cfg.node_number}) ? idx_reg + 5'd1 : idx_reg;
        end
        else
        begin
            dest = {1'b0, job_reg.dest};
        end
        is_last = (cnt_reg == job_reg.count - 1'b1);

        rsp.msg_kind      = job_reg.kind;
        rsp.dest_id       = dest[3:0];
        rsp.out_term      = job_reg.term;
        rsp.vote_yes      = job_reg.yes;
        rsp.out_log_index = job_reg.bcast ? cfg.own_log_length : '0;
        rsp.out_log_term  = (job_reg.bcast && (cfg.own_log_length != '0))
                          ? cfg.own_log_last_term : '0;
        rsp.node_role     = job_reg.role;
        rsp.last          = is_last;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (emit && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = (state_reg == BK_IDLE) && q_valid;
        emit = (state_reg == BK_RUN) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else if (emit)
            begin
                idx_reg <= dest + 5'd1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        if (emit)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    `CLE_ASSERT_IMP(a_bk_cnt_bound, state_reg == BK_RUN, cnt_reg < job_reg.count)
    `CLE_ASSERT_IMP(a_bk_no_self, (state_reg == BK_RUN) && job_reg.bcast,
                    dest != {1'b0, cfg.node_number})
    `CLE_ASSERT_NXT(a_bk_last_idle, emit && is_last, state_reg == BK_IDLE)

endmodule

// File: rtl/core/consensus_leader_election.sv
// Election side of one consensus node: configuration registers and the
// front/queue/back pipeline. Depends on cle_pkg, cle_front, cle_queue, cle_back.
//
// Usage:
//   Requests (ticks, vote requests, vote responses, append entries) enter on
//   in_valid/in_stall/in_req; a request is taken when in_valid is high and
//   in_stall low. Responses leave on out_valid/out_stall/out_rsp; the last
//   response caused by one request has out_rsp.last set. Requests causing no
//   response (most ticks, vote responses) leave only state changes.
//   The first response passes the job queue, the back part's job register and its output register.
//   Throughput: the front takes one request per cycle while the job queue
//   has room. The back drains one job at a time: it takes the job from the
//   queue while idle, then emits its responses one per cycle while out_stall
//   is low, so the back unit's output register sets the sustained rate.
//   When the receiver stalls, the output register holds its response, the
//   back part waits, the queue fills and then in_stall rises.
//   Reset (rst_n low, asynchronous) clears the node to follower, term 0,
//   no vote, timers zero, empties the queue and loads the register defaults.
//   Users write configuration (cfg_we/cfg_addr/cfg_data) only while idle;
//   the block does not enforce this. Addresses past the register list are ignored.
module consensus_leader_election
    import cle_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int TERM_BITS   = TERM_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cle_req_t              in_req,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cle_rsp_t              out_rsp,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_data
);

    cle_cfg_t cfg_reg, cfg_next;

    // job queue link
    logic     q_push;
    cle_job_t q_push_job;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    cle_job_t q_head;

    // register file: plain writes, no read-back
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_NODE_NUMBER:  cfg_next.node_number           = cfg_data[3:0];
                CFG_CLUSTER_SIZE: cfg_next.cluster_size          = cfg_data[4:0];
                CFG_ELECT_TMO:    cfg_next.election_timeout_ms   = cfg_data[8:0];
                CFG_HB_INTERVAL:  cfg_next.heartbeat_interval_ms = cfg_data[7:0];
                CFG_LOG_LENGTH:   cfg_next.own_log_length        = cfg_data;
                CFG_LOG_TERM:     cfg_next.own_log_last_term     = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_number           <= '0;
            cfg_reg.cluster_size          <= CLUSTER_SIZE_RST;
            cfg_reg.election_timeout_ms   <= ELECT_TIMEOUT_RST;
            cfg_reg.heartbeat_interval_ms <= HB_INTERVAL_RST;
            cfg_reg.own_log_length        <= '0;
            cfg_reg.own_log_last_term     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify request, update node state, queue the output work
    cle_front #(
        .MAX_NODES (MAX_NODES),
        .TERM_BITS (TERM_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_push_job)
    );

    cle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_job  (q_head)
    );

    // back: replies and broadcasts, one response per cycle while out_stall is low
    cle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

endmodule
